### hdl/imrt_pkg.sv
// Shared types, constants and command/status structs for the interval map range table.
`timescale 1ns / 1ps
`default_nettype none
package imrt_pkg;

   localparam int TableDepth  = 64;
   localparam int KeyWidth    = 32;
   localparam int ValueWidth  = 8;
   localparam int AddrWidth   = $clog2(TableDepth);
   localparam int CountWidth  = $clog2(TableDepth + 1);
   localparam int FillWidth   = $clog2(TableDepth + 3);
   localparam int EntryWidth  = KeyWidth + ValueWidth;
   localparam int StatusWidth = 2;

   localparam logic [StatusWidth-1:0] StatOk    = 2'd0;
   localparam logic [StatusWidth-1:0] StatEmpty = 2'd1;
   localparam logic [StatusWidth-1:0] StatFull  = 2'd2;

   localparam logic ReqAssign = 1'b0;
   localparam logic ReqLookup = 1'b1;

   typedef struct packed {
      logic                       req_type;
      logic signed [KeyWidth-1:0] key_begin;
      logic signed [KeyWidth-1:0] key_end;
      logic [ValueWidth-1:0]      range_value;
      logic signed [KeyWidth-1:0] lookup_key;
   } req_item_type;

   typedef struct packed {
      logic [ValueWidth-1:0]  found_value;
      logic [StatusWidth-1:0] status;
   } rsp_item_type;

   typedef enum logic [3:0] {
      OpNone,
      OpLoad,
      OpCopy,
      OpSkip,
      OpInsB,
      OpInsE,
      OpFound,
      OpDone,
      OpCfg,
      OpClear
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic lookup;
      logic empty;
      logic lt_b;
      logic le_e;
      logic le_lk;
      logic scan_end;
      logic inserted;
      logic rsp_free;
   } stat_type;

endpackage
`default_nettype wire

### hdl/interval_map_range_table_top.sv
// Top level of the interval map range table.
//
// Holds a canonical sorted table of up to 64 breakpoints (key, value).
// Request channel (req_valid / req_stall / req_data): an item is either an
// assign of range_value over [key_begin, key_end) or a lookup of lookup_key.
// Response channel (rsp_valid / rsp_stall / rsp_data): one item per request
// carrying found_value and status (ok, empty range, table full).
// Config channel (csr_valid / csr_ready / csr_data): writes default_value and
// clears the table to one entry.
// Scan: the block scans the table through a registered RAM read port,
// visiting one entry per pass through S_READ and S_EVAL. One item is
// worked at a time.
// Reset clears the table to one entry of value zero in state S_CLEAR after
// reset drops, during which no item is taken.
// A stalled response holds in the output register; the next item may be
// accepted and worked meanwhile, and finishes once the register frees.
`timescale 1ns / 1ps
`default_nettype none
module interval_map_range_table_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire imrt_pkg::req_item_type              req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output imrt_pkg::rsp_item_type                   rsp_data,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [imrt_pkg::ValueWidth-1:0]     csr_data
);

   imrt_pkg::cmd_type  cmd;
   imrt_pkg::stat_type stat;

   imrt_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .stat(stat), .cmd(cmd)
   );

   imrt_dp u_dp (
      .clock(clock), .reset(reset),
      .cmd(cmd), .stat(stat),
      .req_data(req_data), .csr_data(csr_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

endmodule
`default_nettype wire

### hdl/imrt_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module imrt_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

### hdl/imrt_ctrl.sv
// Controller state machine that sequences table scans, inserts and commits.
`timescale 1ns / 1ps
`default_nettype none
module imrt_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire imrt_pkg::stat_type stat,
   output imrt_pkg::cmd_type       cmd
);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_READ, S_EVAL, S_INSB, S_INSE, S_DONE
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign csr_ready = (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE) || csr_valid;

   always_comb begin
      state_in = state_ff;
      cmd.op   = imrt_pkg::OpNone;
      case (state_ff)
         S_CLEAR: begin
            cmd.op   = imrt_pkg::OpClear;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (csr_valid) begin
               cmd.op   = imrt_pkg::OpCfg;
               state_in = S_CLEAR;
            end else if (req_valid) begin
               cmd.op   = imrt_pkg::OpLoad;
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (!stat.lookup && stat.empty) begin
               state_in = S_DONE;
            end else begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (stat.lookup) begin
               if (stat.scan_end || !stat.le_lk) begin
                  state_in = S_DONE;
               end else begin
                  cmd.op   = imrt_pkg::OpFound;
                  state_in = S_READ;
               end
            end else if (stat.scan_end) begin
               state_in = stat.inserted ? S_DONE : S_INSB;
            end else if (stat.inserted || stat.lt_b) begin
               cmd.op   = imrt_pkg::OpCopy;
               state_in = S_READ;
            end else if (stat.le_e) begin
               cmd.op   = imrt_pkg::OpSkip;
               state_in = S_READ;
            end else begin
               state_in = S_INSB;
            end
         end
         S_INSB: begin
            cmd.op   = imrt_pkg::OpInsB;
            state_in = S_INSE;
         end
         S_INSE: begin
            // the pending entry is still on the read port: evaluate it again
            cmd.op   = imrt_pkg::OpInsE;
            state_in = stat.scan_end ? S_DONE : S_EVAL;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.op   = imrt_pkg::OpDone;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   no_cfg_when_busy: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> !(state_ff == S_EVAL || state_ff == S_DONE))
      else $error("config port ready while busy");
   load_goes_read: assert property (@(posedge clock) disable iff (reset)
      cmd.op == imrt_pkg::OpLoad |=> state_ff == S_READ)
      else $error("load did not start a scan");
   insb_then_inse: assert property (@(posedge clock) disable iff (reset)
      cmd.op == imrt_pkg::OpInsB |=> cmd.op == imrt_pkg::OpInsE)
      else $error("begin insert not followed by end insert");

endmodule
`default_nettype wire

### hdl/imrt_dp.sv
// Datapath: ping-pong breakpoint banks, scan counters, compares and result register.
`timescale 1ns / 1ps
`default_nettype none
module imrt_dp (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire imrt_pkg::cmd_type      cmd,
   output imrt_pkg::stat_type          stat,
   input  wire imrt_pkg::req_item_type req_data,
   input  wire logic [imrt_pkg::ValueWidth-1:0] csr_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output imrt_pkg::rsp_item_type      rsp_data
);

   localparam logic [imrt_pkg::KeyWidth-1:0] SignBit = {1'b1, {(imrt_pkg::KeyWidth-1){1'b0}}};

   imrt_pkg::req_item_type req_ff;
   imrt_pkg::rsp_item_type rsp_ff;
   logic                   rsp_valid_ff;
   logic [imrt_pkg::CountWidth-1:0] i_ff, cnt_ff;
   logic [imrt_pkg::FillWidth-1:0]  n_ff;
   logic bank_ff, have_prev_ff, inserted_ff;
   logic [imrt_pkg::ValueWidth-1:0] last_ff, prev_ff, found_ff, default_ff;

   logic [imrt_pkg::EntryWidth-1:0] rd0, rd1, ent, wr_data;
   logic [imrt_pkg::KeyWidth-1:0]   ent_key, b_enc, e_enc, lk_enc;
   logic [imrt_pkg::ValueWidth-1:0] ent_val, val;
   logic [imrt_pkg::AddrWidth-1:0]  wr_addr;
   logic wr_en, room, full, need_b, need_e, commit;

   assign b_enc   = req_ff.key_begin ^ SignBit;
   assign e_enc   = req_ff.key_end ^ SignBit;
   assign lk_enc  = req_ff.lookup_key ^ SignBit;
   assign val     = req_ff.range_value;
   assign ent     = bank_ff ? rd1 : rd0;
   assign ent_key = ent[imrt_pkg::EntryWidth-1 -: imrt_pkg::KeyWidth];
   assign ent_val = ent[imrt_pkg::ValueWidth-1:0];
   assign room    = n_ff < imrt_pkg::FillWidth'(imrt_pkg::TableDepth);
   assign full    = n_ff > imrt_pkg::FillWidth'(imrt_pkg::TableDepth);
   assign need_b  = !(have_prev_ff && (prev_ff == val));
   assign need_e  = (last_ff != val);
   assign commit  = (req_ff.req_type == imrt_pkg::ReqAssign) && !stat.empty && !full;

   assign stat.lookup   = (req_ff.req_type == imrt_pkg::ReqLookup);
   assign stat.empty    = (b_enc >= e_enc);
   assign stat.lt_b     = (ent_key < b_enc);
   assign stat.le_e     = (ent_key <= e_enc);
   assign stat.le_lk    = (ent_key <= lk_enc);
   assign stat.scan_end = (i_ff == cnt_ff);
   assign stat.inserted = inserted_ff;
   assign stat.rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = n_ff[imrt_pkg::AddrWidth-1:0];
      wr_data = {ent_key, ent_val};
      case (cmd.op)
         imrt_pkg::OpCopy: wr_en = room;
         imrt_pkg::OpInsB: begin
            wr_en   = room && need_b;
            wr_data = {b_enc, val};
         end
         imrt_pkg::OpInsE: begin
            wr_en   = room && need_e;
            wr_data = {e_enc, last_ff};
         end
         imrt_pkg::OpClear: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = {{imrt_pkg::KeyWidth{1'b0}}, default_ff};
         end
         default: wr_en = 1'b0;
      endcase
   end

   // writes always go to the inactive bank
   imrt_ram #(.Width(imrt_pkg::EntryWidth), .Depth(imrt_pkg::TableDepth)) u_bank0 (
      .clock(clock), .wr_en(wr_en && bank_ff), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(i_ff[imrt_pkg::AddrWidth-1:0]), .rd_data(rd0)
   );
   imrt_ram #(.Width(imrt_pkg::EntryWidth), .Depth(imrt_pkg::TableDepth)) u_bank1 (
      .clock(clock), .wr_en(wr_en && !bank_ff), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(i_ff[imrt_pkg::AddrWidth-1:0]), .rd_data(rd1)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= imrt_pkg::CountWidth'(1);
         bank_ff      <= 1'b0;
         default_ff   <= '0;
         i_ff         <= '0;
         n_ff         <= '0;
         have_prev_ff <= 1'b0;
         inserted_ff  <= 1'b0;
      end else begin
         if (!rsp_stall && cmd.op != imrt_pkg::OpDone) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.op)
            imrt_pkg::OpLoad: begin
               req_ff       <= req_data;
               i_ff         <= '0;
               n_ff         <= '0;
               have_prev_ff <= 1'b0;
               inserted_ff  <= 1'b0;
               found_ff     <= '0;
            end
            imrt_pkg::OpCopy: begin
               n_ff         <= n_ff + 1'b1;
               prev_ff      <= ent_val;
               have_prev_ff <= 1'b1;
               last_ff      <= ent_val;
               i_ff         <= i_ff + 1'b1;
            end
            imrt_pkg::OpSkip: begin
               last_ff <= ent_val;
               i_ff    <= i_ff + 1'b1;
            end
            imrt_pkg::OpInsB: begin
               if (need_b) begin
                  n_ff <= n_ff + 1'b1;
               end
            end
            imrt_pkg::OpInsE: begin
               if (need_e) begin
                  n_ff <= n_ff + 1'b1;
               end
               inserted_ff <= 1'b1;
            end
            imrt_pkg::OpFound: begin
               found_ff <= ent_val;
               i_ff     <= i_ff + 1'b1;
            end
            imrt_pkg::OpDone: begin
               if (commit) begin
                  bank_ff <= !bank_ff;
                  cnt_ff  <= n_ff[imrt_pkg::CountWidth-1:0];
               end
               rsp_valid_ff <= 1'b1;
               rsp_ff.found_value <= stat.lookup ? found_ff : '0;
               if (stat.lookup) begin
                  rsp_ff.status <= imrt_pkg::StatOk;
               end else if (stat.empty) begin
                  rsp_ff.status <= imrt_pkg::StatEmpty;
               end else if (full) begin
                  rsp_ff.status <= imrt_pkg::StatFull;
               end else begin
                  rsp_ff.status <= imrt_pkg::StatOk;
               end
            end
            imrt_pkg::OpCfg: default_ff <= csr_data;
            imrt_pkg::OpClear: begin
               bank_ff <= !bank_ff;
               cnt_ff  <= imrt_pkg::CountWidth'(1);
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   count_in_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != '0 && cnt_ff <= imrt_pkg::CountWidth'(imrt_pkg::TableDepth))
      else $error("entry count out of range");
   copy_within_table: assert property (@(posedge clock) disable iff (reset)
      cmd.op == imrt_pkg::OpCopy |-> i_ff < cnt_ff)
      else $error("copy past last valid entry");
   commit_count: assert property (@(posedge clock) disable iff (reset)
      cmd.op == imrt_pkg::OpDone && commit |=> cnt_ff == $past(n_ff[imrt_pkg::CountWidth-1:0]))
      else $error("entry count not taken from fill count");

endmodule
`default_nettype wire
